### sv/opte_pkg.sv
package opte_pkg;

  localparam int TIME_W = 63;
  localparam int ACC_W  = TIME_W + 1;
  localparam int ALU_W  = TIME_W + 2;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Request kinds.
  localparam logic [2:0] KIND_CHECK    = 3'd0;
  localparam logic [2:0] KIND_STOP     = 3'd1;
  localparam logic [2:0] KIND_ARM_ONE  = 3'd2;
  localparam logic [2:0] KIND_ARM_PER  = 3'd3;
  localparam logic [2:0] KIND_CLEAR    = 3'd4;

  // Timer modes.
  localparam logic [1:0] MODE_STOP     = 2'd0;
  localparam logic [1:0] MODE_ONESHOT  = 2'd1;
  localparam logic [1:0] MODE_PERIODIC = 2'd2;

  // Register offsets on the configuration port.
  localparam logic [3:0] ADDR_PERIOD   = 4'h0;

  // Operation handed to the shared adder.
  typedef struct packed {
    logic [ACC_W-1:0] op_a;
    logic [ACC_W-1:0] op_b;
    logic             sub;
  } alu_req_t;

endpackage

### sv/opte_alu.sv
module opte_alu
  import opte_pkg::*;
(
  input  alu_req_t         req,
  output logic [ALU_W-1:0] res
);

  // One extra bit on top, so that bit ALU_W-1 is the borrow of a subtraction.
  logic [ALU_W-1:0] a_ext;
  logic [ALU_W-1:0] b_ext;

  assign a_ext = {1'b0, req.op_a};
  assign b_ext = {1'b0, req.op_b};
  assign res   = req.sub ? (a_ext - b_ext) : (a_ext + b_ext);

endmodule

### sv/oneshot_periodic_timer_event.sv
// Deadline timer (stopped, one-shot, periodic) with a sticky signaled flag.
// Each request is decoded in EVAL and its result is loaded in PUT; a periodic check that
// fires also passes LATE, and one that is still late after one period then runs the
// 63-step remainder loop through the shared 65-bit adder, followed by STEP, SUM and ADD.
// One request at a time: at the earliest, a new request is taken the cycle after the result is loaded.
// Reset (rst, synchronous): mode stopped, wake-up and first deadline zero, flag clear, period one.
module oneshot_periodic_timer_event
  import opte_pkg::*;
(
  input  logic              clk,
  input  logic              rst,

  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        kind,
  input  logic [TIME_W-1:0] time_ns,

  output logic              out_valid,
  input  logic              out_stall,
  output logic              fired,
  output logic              signaled_flag,
  output logic [TIME_W-1:0] wakeup_ns,
  output logic [1:0]        mode_out,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  // Sequencer codes. Every step from EVAL to ADD drives the one shared adder.
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a request
  localparam logic [2:0] S_EVAL = 3'd1;  // decode the request, wake-up plus one period
  localparam logic [2:0] S_LATE = 3'd2;  // still late? then elapsed = now - first deadline
  localparam logic [2:0] S_DIV  = 3'd3;  // one remainder bit per cycle
  localparam logic [2:0] S_STEP = 3'd4;  // elapsed - remainder = whole periods elapsed
  localparam logic [2:0] S_SUM  = 3'd5;  // plus one period, saturated
  localparam logic [2:0] S_ADD  = 3'd6;  // plus first deadline, saturated
  localparam logic [2:0] S_PUT  = 3'd7;  // load the output register

  logic [2:0]        state;
  logic [2:0]        kind_q;
  logic [TIME_W-1:0] now_q;

  // Timer state.
  logic [TIME_W-1:0] period;
  logic [1:0]        mode;
  logic [TIME_W-1:0] next_wakeup;
  logic [TIME_W-1:0] first_deadline;
  logic              signaled;
  logic              fired_q;

  // Catch-up datapath.
  logic [ACC_W-1:0]  acc;
  logic [TIME_W-1:0] dvd;
  logic [TIME_W-1:0] rem;
  logic [5:0]        cnt;

  logic [TIME_W-1:0] per_eff;
  logic [ACC_W-1:0]  div_r;
  alu_req_t          alu_req;
  logic [ALU_W-1:0]  alu_res;
  logic [ACC_W-1:0]  alu_sat;
  logic              cfg_wr;
  logic              eval_fire;

  // A period of zero behaves as a period of one.
  assign per_eff = (period == '0) ? TIME_W'(1) : period;

  // Partial remainder with the next dividend bit brought in from the top.
  assign div_r = {rem, dvd[TIME_W-1]};

  // Sums of two values below 2^63 never reach 2^64, so bit 63 alone flags saturation.
  assign alu_sat = alu_res[ACC_W-1] ? {1'b0, TIME_MAX} : alu_res[ACC_W-1:0];

  // A check fires when an armed timer's wake-up time lies strictly before the current time.
  assign eval_fire = (kind_q == KIND_CHECK) &&
                     ((mode == MODE_ONESHOT) || (mode == MODE_PERIODIC)) &&
                     (next_wakeup < now_q);

  assign in_stall = (state != S_IDLE);

  // The configuration port always completes in its access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr == ADDR_PERIOD) ? {1'b0, period} : 64'd0;

  // Operand selection for the shared adder, one operation per sequencer step.
  always_comb begin
    alu_req = '{op_a: '0, op_b: '0, sub: 1'b0};
    unique case (state)
      S_EVAL: begin
        alu_req = '{op_a: {1'b0, next_wakeup}, op_b: {1'b0, per_eff}, sub: 1'b0};
      end
      S_LATE: begin
        alu_req = '{op_a: {1'b0, now_q}, op_b: {1'b0, first_deadline}, sub: 1'b1};
      end
      S_DIV: begin
        alu_req = '{op_a: div_r, op_b: {1'b0, per_eff}, sub: 1'b1};
      end
      S_STEP: begin
        alu_req = '{op_a: acc, op_b: {1'b0, rem}, sub: 1'b1};
      end
      S_SUM: begin
        alu_req = '{op_a: acc, op_b: {1'b0, per_eff}, sub: 1'b0};
      end
      S_ADD: begin
        alu_req = '{op_a: acc, op_b: {1'b0, first_deadline}, sub: 1'b0};
      end
      default: begin
        alu_req = '{op_a: '0, op_b: '0, sub: 1'b0};
      end
    endcase
  end

  opte_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // Configuration register. Writes must arrive only while the timer is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      period <= TIME_W'(1);
    end else if (cfg_wr && (paddr[3] == 1'b0)) begin
      period <= pwdata[TIME_W-1:0];
    end
  end

  // Sequencer, timer state and the catch-up datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      mode           <= MODE_STOP;
      next_wakeup    <= '0;
      first_deadline <= '0;
      signaled       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      // The result is taken by the consumer; in the load step the output register
      // is refilled instead.
      if (out_valid && !out_stall && (state != S_PUT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind_q <= kind;
            now_q  <= time_ns;
            state  <= S_EVAL;
          end
        end

        S_EVAL: begin
          fired_q <= eval_fire;
          state   <= (eval_fire && (mode == MODE_PERIODIC)) ? S_LATE : S_PUT;
          case (kind_q)
            KIND_CHECK: begin
              if (eval_fire && (mode == MODE_ONESHOT)) begin
                // A one-shot timer signals once and stops.
                signaled    <= 1'b1;
                next_wakeup <= '0;
                mode        <= MODE_STOP;
              end else if (eval_fire) begin
                signaled <= 1'b1;
                acc      <= alu_sat;
              end
            end
            KIND_STOP: begin
              mode        <= MODE_STOP;
              next_wakeup <= '0;
            end
            KIND_ARM_ONE: begin
              mode           <= MODE_ONESHOT;
              next_wakeup    <= now_q;
              first_deadline <= now_q;
            end
            KIND_ARM_PER: begin
              mode           <= MODE_PERIODIC;
              next_wakeup    <= now_q;
              first_deadline <= now_q;
            end
            KIND_CLEAR: begin
              signaled <= 1'b0;
            end
            default: begin
              // Unused kinds leave the timer untouched.
            end
          endcase
        end

        S_LATE: begin
          if (acc < {1'b0, now_q}) begin
            // Still late after one period: find the next whole period after the
            // first deadline. Before the first deadline the elapsed time is zero.
            acc   <= alu_res[ACC_W-1] ? '0 : {1'b0, alu_res[TIME_W-1:0]};
            dvd   <= alu_res[ACC_W-1] ? '0 : alu_res[TIME_W-1:0];
            rem   <= '0;
            cnt   <= 6'(TIME_W - 1);
            state <= S_DIV;
          end else begin
            next_wakeup <= acc[TIME_W-1:0];
            state       <= S_PUT;
          end
        end

        S_DIV: begin
          // Restoring step: keep the difference when there is no borrow.
          rem <= alu_res[ALU_W-1] ? div_r[TIME_W-1:0] : alu_res[TIME_W-1:0];
          dvd <= {dvd[TIME_W-2:0], 1'b0};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            state <= S_STEP;
          end
        end

        S_STEP: begin
          acc   <= alu_res[ACC_W-1:0];
          state <= S_SUM;
        end

        S_SUM: begin
          acc   <= alu_sat;
          state <= S_ADD;
        end

        S_ADD: begin
          next_wakeup <= alu_sat[TIME_W-1:0];
          state       <= S_PUT;
        end

        S_PUT: begin
          // Wait for the output register to be free, then publish the state.
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            fired         <= fired_q;
            signaled_flag <= signaled;
            wakeup_ns     <= next_wakeup;
            mode_out      <= mode;
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A request is only ever taken with the sequencer idle.
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_EVAL))
    else $error("request accepted outside idle");

  // A stopped timer always reports a zero wake-up time.
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_STOP) |-> (next_wakeup == '0))
    else $error("stopped timer holds a wake-up time");

  // The partial remainder stays below the period throughout the loop.
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < per_eff))
    else $error("remainder out of range");

  // The catch-up loop runs only for a periodic timer.
  a_div_mode: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (mode == MODE_PERIODIC))
    else $error("catch-up running outside periodic mode");

endmodule

### tb/oneshot_periodic_timer_event_tb.sv
`timescale 1ns / 100ps

module oneshot_periodic_timer_event_tb;
  import opte_pkg::*;

  // Kinds above the clear request carry no meaning and must leave the timer untouched.
  localparam logic [2:0]  KIND_RSVD_FIRST = 3'd5;
  localparam logic [2:0]  KIND_RSVD_LAST  = 3'd7;
  localparam logic [63:0] T_MAX64         = {1'b0, TIME_MAX};

  typedef struct {
    logic [2:0]        kind;
    logic [TIME_W-1:0] at;
  } timer_request_t;

  typedef struct packed {
    logic              fired;
    logic              signaled;
    logic [TIME_W-1:0] wakeup;
    logic [1:0]        mode;
  } timer_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        kind = KIND_CHECK;
  logic [TIME_W-1:0] time_ns = '0;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              fired;
  logic              signaled_flag;
  logic [TIME_W-1:0] wakeup_ns;
  logic [1:0]        mode_out;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [3:0]        paddr = ADDR_PERIOD;
  logic [63:0]       pwdata = '0;
  logic [63:0]       prdata;
  logic              pready;

  oneshot_periodic_timer_event u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .time_ns       (time_ns),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .fired         (fired),
    .signaled_flag (signaled_flag),
    .wakeup_ns     (wakeup_ns),
    .mode_out      (mode_out),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Requests waiting to be offered, and the results the timer owes us, oldest first.
  timer_request_t pending_requests[$];
  timer_result_t  expected_results[$];

  // Our own copy of the timer state, advanced once per accepted request.
  logic [1:0]        tm_mode = MODE_STOP;
  logic [TIME_W-1:0] tm_wakeup = '0;
  logic [TIME_W-1:0] tm_first = '0;
  logic              tm_signaled = 1'b0;
  logic [TIME_W-1:0] tm_period = 63'd1;

  int fault_count = 0;
  int results_seen = 0;

  // Current time of the stimulus generator; moves forward mostly, backwards now and then.
  logic [63:0] gen_now = '0;

  function automatic void report_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("ERROR: %s", msg);
  endfunction

  function automatic logic [63:0] sat_add_time(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > T_MAX64) ? T_MAX64 : s;
  endfunction

  function automatic logic [TIME_W-1:0] rand63();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TIME_W-1:0];
  endfunction

  // Works out the result of one accepted request and moves the timer copy on.
  function automatic void predict_request(input logic [2:0] req_kind,
                                          input logic [TIME_W-1:0] req_time);
    timer_result_t res;
    logic [63:0]   now;
    logic [63:0]   per;
    logic [63:0]   nxt;
    logic [63:0]   elapsed;
    logic [127:0]  step;
    now = {1'b0, req_time};
    // A period of zero behaves as a period of one.
    per = (tm_period == '0) ? 64'd1 : {1'b0, tm_period};
    res.fired = 1'b0;
    case (req_kind)
      KIND_CHECK: begin
        nxt = {1'b0, tm_wakeup};
        // The deadline has passed only when it lies strictly before the current time.
        if (tm_mode != MODE_STOP && nxt < now) begin
          res.fired = 1'b1;
          tm_signaled = 1'b1;
          if (tm_mode == MODE_ONESHOT) begin
            tm_mode = MODE_STOP;
            tm_wakeup = '0;
          end else begin
            nxt = sat_add_time(nxt, per);
            if (nxt < now) begin
              // Still late: jump to the next whole period after the first deadline.
              elapsed = (now > {1'b0, tm_first}) ? now - {1'b0, tm_first} : 64'd0;
              step = ({64'd0, elapsed / per} + 128'd1) * {64'd0, per};
              if (step > {64'd0, T_MAX64}) step = {64'd0, T_MAX64};
              nxt = sat_add_time(step[63:0], {1'b0, tm_first});
            end
            tm_wakeup = nxt[TIME_W-1:0];
          end
        end
      end
      KIND_STOP: begin
        tm_mode = MODE_STOP;
        tm_wakeup = '0;
      end
      KIND_ARM_ONE, KIND_ARM_PER: begin
        tm_mode = (req_kind == KIND_ARM_ONE) ? MODE_ONESHOT : MODE_PERIODIC;
        tm_wakeup = req_time;
        tm_first = req_time;
      end
      KIND_CLEAR: begin
        tm_signaled = 1'b0;
      end
      default: begin
      end
    endcase
    res.signaled = tm_signaled;
    res.wakeup = tm_wakeup;
    res.mode = tm_mode;
    expected_results.push_back(res);
  endfunction

  function automatic void queue_request(input logic [2:0] k, input logic [TIME_W-1:0] t);
    timer_request_t r;
    r.kind = k;
    r.at = t;
    pending_requests.push_back(r);
  endfunction

  // A time step on the period's scale: tiny, half, one or a few periods, or wild.
  function automatic logic [63:0] time_offset(input logic [63:0] per);
    logic [127:0] prod;
    case ($urandom_range(0, 5))
      0: return 64'($urandom_range(0, 2));
      1: return per;
      2: return sat_add_time(per, 64'($urandom_range(1, 3)));
      3: begin
        prod = {64'd0, per} * 128'($urandom_range(2, 6));
        return (prod > {64'd0, T_MAX64}) ? T_MAX64 : prod[63:0];
      end
      4: return per >> 1;
      default: return {1'b0, rand63()} >> $urandom_range(0, 62);
    endcase
  endfunction

  // Mostly well-formed episodes: arm a timer, then check it at advancing times, with
  // stops, clears, reserved kinds, backward checks and plain noise mixed in.
  task automatic queue_random_phase(input int count, input logic [63:0] per);
    int queued;
    int n_checks;
    int r;
    logic [63:0] t;
    queued = 0;
    while (queued < count) begin
      if ($urandom_range(0, 7) == 0 || (gen_now == T_MAX64 && $urandom_range(0, 1) == 0))
        gen_now = {1'b0, rand63()} >> $urandom_range(0, 62);
      r = $urandom_range(0, 99);
      if (r < 8) begin
        queue_request(3'($urandom_range(KIND_CHECK, KIND_RSVD_LAST)), rand63());
        queued++;
        continue;
      end
      t = ($urandom_range(0, 3) == 0) ? gen_now : sat_add_time(gen_now, time_offset(per));
      queue_request((r < 65) ? KIND_ARM_PER : KIND_ARM_ONE, t[TIME_W-1:0]);
      queued++;
      n_checks = $urandom_range(1, 8);
      for (int i = 0; i < n_checks; i++) begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          queue_request(KIND_CLEAR, rand63());
        end else if (r < 10) begin
          queue_request(KIND_STOP, rand63());
        end else if (r < 13) begin
          queue_request(3'($urandom_range(KIND_RSVD_FIRST, KIND_RSVD_LAST)), rand63());
        end else if (r < 20) begin
          // A check at an earlier time than the generator has reached.
          t = {1'b0, rand63()} % (gen_now + 64'd1);
          queue_request(KIND_CHECK, t[TIME_W-1:0]);
        end else begin
          gen_now = sat_add_time(gen_now, time_offset(per));
          queue_request(KIND_CHECK, gen_now[TIME_W-1:0]);
        end
        queued++;
      end
    end
  endtask

  // Waits until every queued request has been taken and every result has come back.
  // Sampled on the falling edge so that all updates of the rising edge have settled.
  task automatic wait_until_idle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // Writes the period register, then reads it back. Only called while the timer is idle.
  task automatic write_period(input logic [TIME_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_PERIOD;
    pwdata <= {1'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    tm_period = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[TIME_W-1:0] !== value)
      report_fault($sformatf("period read back: expected %0d, got %0d", value, prdata));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Sender: bursts of requests separated by gaps; a stalled request is held as it is.
  int burst_left = 0;
  int gap_left = 0;
  timer_request_t next_req;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_request(kind, time_ns);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          next_req = pending_requests.pop_front();
          kind <= next_req.kind;
          time_ns <= next_req.at;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 23);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a changing series of random stall patterns, plus one long hold-off
  // part way through, during which the sender keeps offering so the timer backs up.
  int hold_left = 0;
  bit hold_done = 1'b0;
  int pat_mode = 0;
  int pat_left = 0;
  int pat_cycle = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && results_seen >= 350) begin
      hold_done = 1'b1;
      hold_left = 400;
      out_stall <= 1'b1;
    end else begin
      if (pat_left == 0) begin
        pat_mode = $urandom_range(0, 3);
        pat_left = $urandom_range(16, 96);
      end else begin
        pat_left--;
      end
      pat_cycle++;
      case (pat_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 30);
        2: out_stall <= ($urandom_range(0, 99) < 70);
        default: out_stall <= (pat_cycle % 5 < 2);
      endcase
    end
  end

  // Result checker: each accepted result is compared with the oldest expectation.
  timer_result_t want;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        report_fault($sformatf({"result with nothing expected:",
                                " fired=%0b signaled=%0b wakeup=%0d mode=%0d"},
                               fired, signaled_flag, wakeup_ns, mode_out));
      end else begin
        want = expected_results.pop_front();
        if (fired !== want.fired || signaled_flag !== want.signaled ||
            wakeup_ns !== want.wakeup || mode_out !== want.mode)
          report_fault($sformatf({"result %0d: expected fired=%0b signaled=%0b wakeup=%0d mode=%0d,",
                                  " got fired=%0b signaled=%0b wakeup=%0d mode=%0d"},
                                 results_seen, want.fired, want.signaled, want.wakeup, want.mode,
                                 fired, signaled_flag, wakeup_ns, mode_out));
      end
    end
  end

  // Main sequence: directed requests, then random phases under several period settings.
  initial begin
    logic [TIME_W-1:0] phase_periods[5];
    logic [63:0]       gen_per;
    phase_periods[0] = 63'd1;
    phase_periods[1] = '0;
    phase_periods[2] = 63'($urandom_range(2, 1000));
    phase_periods[3] = TIME_MAX;
    phase_periods[4] = rand63() | (63'd1 << 40);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    write_period(63'd10);
    // A stopped timer never fires, whatever the time.
    queue_request(KIND_CHECK, '0);
    queue_request(KIND_CHECK, TIME_MAX);
    // One-shot: a deadline equal to the current time has not passed yet.
    queue_request(KIND_ARM_ONE, 63'd100);
    queue_request(KIND_CHECK, 63'd100);
    queue_request(KIND_CHECK, 63'd101);
    queue_request(KIND_CHECK, 63'd500);
    queue_request(KIND_CLEAR, TIME_MAX);
    // Periodic: before the first deadline, one period on, then a catch-up.
    queue_request(KIND_ARM_PER, 63'd100);
    queue_request(KIND_CHECK, 63'd99);
    queue_request(KIND_CHECK, 63'd105);
    queue_request(KIND_CHECK, 63'd110);
    queue_request(KIND_CHECK, 63'd145);
    queue_request(KIND_STOP, '0);
    // The sum of deadline and period saturates at the top of the range.
    queue_request(KIND_ARM_PER, TIME_MAX - 63'd5);
    queue_request(KIND_CHECK, TIME_MAX);
    queue_request(KIND_CHECK, TIME_MAX);
    // The catch-up step itself saturates.
    queue_request(KIND_ARM_PER, '0);
    queue_request(KIND_CHECK, TIME_MAX);
    queue_request(KIND_ARM_ONE, TIME_MAX);
    queue_request(KIND_CHECK, TIME_MAX);
    queue_request(KIND_CLEAR, '0);
    for (int k = KIND_RSVD_FIRST; k <= KIND_RSVD_LAST; k++) queue_request(3'(k), rand63());
    queue_request(KIND_ARM_ONE, '0);
    queue_request(KIND_CHECK, 63'd1);
    queue_request(KIND_STOP, TIME_MAX);
    wait_until_idle();

    foreach (phase_periods[p]) begin
      write_period(phase_periods[p]);
      gen_per = (phase_periods[p] == '0) ? 64'd1 : {1'b0, phase_periods[p]};
      queue_random_phase(135, gen_per);
      wait_until_idle();
    end

    // Anything arriving now would be a result nobody asked for.
    repeat (20) @(posedge clk);
    if (fault_count == 0 && expected_results.size() == 0) begin
      $display("oneshot_periodic_timer_event_tb passed");
    end else begin
      $display("oneshot_periodic_timer_event_tb failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, including the long hold-off.
  initial begin
    #10_000_000;
    $display("oneshot_periodic_timer_event_tb failed");
    $finish;
  end

endmodule
